[hw/rtl/hid_report_descriptor_parser_core_assert.svh]
// Assertion macros for the report descriptor parser.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_CORE_ASSERT_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_CORE_ASSERT_SVH
// Check that an implication holds on every clock edge outside reset.
`define HRDP_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Check that an implication holds in the cycle after its condition.
`define HRDP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

[hw/rtl/hrdp_pkg.sv]
// Shared types and constants of the report descriptor parser.
`default_nettype none
package hrdp_pkg;
   localparam int unsigned PushStackDepth = 16;
   localparam int unsigned MaxFields = 256;
   localparam int unsigned DepthWidth = $clog2(PushStackDepth + 1);
   localparam int unsigned IdxWidth = (PushStackDepth > 1) ? $clog2(PushStackDepth) : 1;
   localparam int unsigned CountWidth = $clog2(MaxFields + 1);

   localparam logic [7:0] LongItemHeader = 8'hFE;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_SHORT_DATA = 2'd1,
      PHASE_LONG_LEN = 2'd2,
      PHASE_LONG_SKIP = 2'd3
   } phase_type;

   localparam logic [1:0] TYPE_MAIN = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL = 2'd1;
   localparam logic [1:0] TYPE_LOCAL = 2'd2;

   localparam logic [3:0] MAIN_INPUT = 4'h8;
   localparam logic [3:0] MAIN_OUTPUT = 4'h9;
   localparam logic [3:0] MAIN_COLLECTION = 4'hA;
   localparam logic [3:0] MAIN_FEATURE = 4'hB;
   localparam logic [3:0] MAIN_END_COLLECTION = 4'hC;

   localparam logic [3:0] GLB_PAGE = 4'h0;
   localparam logic [3:0] GLB_LOG_MIN = 4'h1;
   localparam logic [3:0] GLB_LOG_MAX = 4'h2;
   localparam logic [3:0] GLB_PHY_MIN = 4'h3;
   localparam logic [3:0] GLB_PHY_MAX = 4'h4;
   localparam logic [3:0] GLB_EXPONENT = 4'h5;
   localparam logic [3:0] GLB_UNIT = 4'h6;
   localparam logic [3:0] GLB_SIZE = 4'h7;
   localparam logic [3:0] GLB_ID = 4'h8;
   localparam logic [3:0] GLB_COUNT = 4'h9;
   localparam logic [3:0] GLB_PUSH = 4'hA;
   localparam logic [3:0] GLB_POP = 4'hB;

   localparam logic [3:0] LOC_USAGE = 4'h0;
   localparam logic [3:0] LOC_USAGE_MIN = 4'h1;
   localparam logic [3:0] LOC_USAGE_MAX = 4'h2;

   localparam logic [1:0] KIND_INPUT = 2'd0;
   localparam logic [1:0] KIND_OUTPUT = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   // Global state that push and pop save and restore.
   typedef struct packed {
      logic [15:0] page;
      logic [31:0] log_min;
      logic [31:0] log_max;
      logic [31:0] phy_min;
      logic [31:0] phy_max;
      logic [31:0] unit;
      logic [3:0] exponent;
      logic [31:0] size;
      logic [31:0] count;
      logic [7:0] id;
   } global_type;

   // One complete short item.
   typedef struct packed {
      logic valid;
      logic [1:0] code;
      logic [1:0] kind;
      logic [3:0] tag;
      logic [31:0] value;
   } item_type;

   // Sign-extend item data by its size code.
   function automatic logic [31:0] sign_by_size(input logic [31:0] v, input logic [1:0] code);
      logic [31:0] r;
      case (code)
         2'd1: r = {{24{v[7]}}, v[7:0]};
         2'd2: r = {{16{v[15]}}, v[15:0]};
         2'd3: r = v;
         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

[hw/rtl/hrdp_item_asm.sv]
// Byte-level item assembler: yields one complete item per short item; long items yield none.
`default_nettype none
module hrdp_item_asm (
   input wire logic clock,
   input wire logic reset,
   input wire logic take,
   input wire logic [7:0] data_byte,
   input wire logic restart,
   output hrdp_pkg::item_type item
);
   hrdp_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [8:0] remain_ff, remain_in, remain_cur;
   logic [7:0] header_ff, header_in, header_cur;
   logic [31:0] data_ff, data_in, data_cur;
   logic [8:0] dec;

   // Apply descriptor restart before this byte.
   always_comb begin
      phase_cur = restart ? hrdp_pkg::PHASE_HEADER : phase_ff;
      remain_cur = restart ? 9'd0 : remain_ff;
      header_cur = restart ? 8'd0 : header_ff;
      data_cur = restart ? 32'd0 : data_ff;
   end

   // Advance the item phase for one byte.
   always_comb begin
      phase_in = phase_cur;
      remain_in = remain_cur;
      header_in = header_cur;
      data_in = data_cur;
      item = '0;
      dec = (remain_cur != 9'd0) ? remain_cur - 9'd1 : 9'd0;
      case (phase_cur)
         hrdp_pkg::PHASE_SHORT_DATA: begin
            data_in = {data_byte, data_cur[31:8]};
            remain_in = dec;
            if (dec == 9'd0) begin
               item.valid = 1'b1;
               item.code = header_cur[1:0];
               item.kind = header_cur[3:2];
               item.tag = header_cur[7:4];
               case (header_cur[1:0])
                  2'd1: item.value = {24'd0, data_in[31:24]};
                  2'd2: item.value = {16'd0, data_in[31:16]};
                  2'd3: item.value = data_in;
                  default: item.value = 32'd0;
               endcase
               phase_in = hrdp_pkg::PHASE_HEADER;
               data_in = 32'd0;
            end
         end
         hrdp_pkg::PHASE_LONG_LEN: begin
            remain_in = {1'b0, data_byte} + 9'd1;
            phase_in = hrdp_pkg::PHASE_LONG_SKIP;
         end
         hrdp_pkg::PHASE_LONG_SKIP: begin
            remain_in = dec;
            if (dec == 9'd0) phase_in = hrdp_pkg::PHASE_HEADER;
         end
         default: begin
            header_in = data_byte;
            data_in = 32'd0;
            if (data_byte == hrdp_pkg::LongItemHeader) begin
               phase_in = hrdp_pkg::PHASE_LONG_LEN;
            end else if (data_byte[1:0] == 2'd0) begin
               remain_in = 9'd0;
               item.valid = 1'b1;
               item.code = 2'd0;
               item.kind = data_byte[3:2];
               item.tag = data_byte[7:4];
               item.value = 32'd0;
            end else begin
               remain_in = (data_byte[1:0] == 2'd3) ? 9'd4 : {7'd0, data_byte[1:0]};
               phase_in = hrdp_pkg::PHASE_SHORT_DATA;
            end
         end
      endcase
   end

   // Hold assembler state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrdp_pkg::PHASE_HEADER;
         remain_ff <= 9'd0;
         header_ff <= 8'd0;
         data_ff <= 32'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         remain_ff <= remain_in;
         header_ff <= header_in;
         data_ff <= data_in;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/hid_report_descriptor_parser_core.sv]
// Top level of the HID report descriptor parser.
// Usage:
//   The req_ channel carries one descriptor byte per transfer; raise
//   req_start_of_descriptor with the first byte of a descriptor to clear all
//   parser state before that byte is taken.
//   The rsp_ channel delivers one field record for each Input, Output or
//   Feature main item, at most 256 records per report kind.
//   Output: the record is registered and appears on rsp_ in the cycle after
//   the byte that completes the main item is accepted.
//   Throughput: one byte per cycle; the item assembler and the global state
//   update together and the result register is the only stage, so a byte is
//   taken whenever the result register is empty or being emptied in the
//   same cycle.
//   Stall: while rsp_stall holds a record, req_stall rises and no byte is
//   taken; the record and its payload stay stable.
//   Reset: synchronous; clears the parser, the offsets and the result valid
//   flag. Push stack entries and the record payload hold no reset value.
`default_nettype none
`include "hid_report_descriptor_parser_core_assert.svh"
module hid_report_descriptor_parser_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [7:0] req_descriptor_byte,
   input wire logic req_start_of_descriptor,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_report_kind,
   output logic [7:0] rsp_report_number,
   output logic [31:0] rsp_main_flags,
   output logic [31:0] rsp_first_usage,
   output logic [31:0] rsp_final_usage,
   output logic [63:0] rsp_logical_range,
   output logic [63:0] rsp_physical_range,
   output logic [31:0] rsp_unit_code,
   output logic [3:0] rsp_unit_power,
   output logic [31:0] rsp_bits_per_element,
   output logic [31:0] rsp_element_count,
   output logic [31:0] rsp_field_bit_position
);
   localparam int unsigned DW = hrdp_pkg::DepthWidth;
   localparam int unsigned IW = hrdp_pkg::IdxWidth;
   localparam int unsigned CW = hrdp_pkg::CountWidth;

   logic take;
   hrdp_pkg::item_type item;
   hrdp_pkg::global_type glb_ff, glb_in, glb_cur;
   hrdp_pkg::global_type stack_mem [hrdp_pkg::PushStackDepth];
   hrdp_pkg::global_type top_ff;
   logic [DW-1:0] depth_ff, depth_in, depth_cur;
   logic seen_ff, seen_in, seen_cur;
   logic [31:0] umin_ff, umin_in, umin_cur, umax_ff, umax_in, umax_cur;
   logic [31:0] offset_ff [3];
   logic [31:0] offset_in [3];
   logic [CW-1:0] emitted_ff [3];
   logic [CW-1:0] emitted_in [3];
   logic push_we, pop_now;
   logic [IW-1:0] push_idx, below_idx;
   logic emit;
   logic [1:0] kind;
   logic [31:0] cur_offset;
   logic [CW-1:0] cur_emitted;
   logic [31:0] product;
   logic [31:0] usage_word;
   logic out_valid_ff;

   assign take = req_valid && !req_stall;
   assign req_stall = out_valid_ff && rsp_stall;

   hrdp_item_asm u_asm (
      .clock(clock),
      .reset(reset),
      .take(take),
      .data_byte(req_descriptor_byte),
      .restart(req_start_of_descriptor),
      .item(item)
   );

   // Clear state at a descriptor start.
   always_comb begin
      glb_cur = req_start_of_descriptor ? '0 : glb_ff;
      depth_cur = req_start_of_descriptor ? '0 : depth_ff;
      seen_cur = req_start_of_descriptor ? 1'b0 : seen_ff;
      umin_cur = req_start_of_descriptor ? 32'd0 : umin_ff;
      umax_cur = req_start_of_descriptor ? 32'd0 : umax_ff;
   end

   // Select the report kind and its counters.
   always_comb begin
      case (item.tag)
         hrdp_pkg::MAIN_OUTPUT: kind = hrdp_pkg::KIND_OUTPUT;
         hrdp_pkg::MAIN_FEATURE: kind = hrdp_pkg::KIND_FEATURE;
         default: kind = hrdp_pkg::KIND_INPUT;
      endcase
      cur_offset = req_start_of_descriptor ? 32'd0 : offset_ff[kind];
      cur_emitted = req_start_of_descriptor ? '0 : emitted_ff[kind];
      product = glb_cur.size * glb_cur.count;
      usage_word = {glb_cur.page, item.value[15:0]};
   end

   assign push_idx = depth_cur[IW-1:0];
   assign below_idx = IW'(depth_cur - DW'(2));

   // Apply one completed item.
   always_comb begin
      glb_in = glb_cur;
      depth_in = depth_cur;
      seen_in = seen_cur;
      umin_in = umin_cur;
      umax_in = umax_cur;
      push_we = 1'b0;
      pop_now = 1'b0;
      emit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         offset_in[k] = req_start_of_descriptor ? 32'd0 : offset_ff[k];
         emitted_in[k] = req_start_of_descriptor ? '0 : emitted_ff[k];
      end
      if (item.valid) begin
         case (item.kind)
            hrdp_pkg::TYPE_MAIN: begin
               case (item.tag)
                  hrdp_pkg::MAIN_INPUT, hrdp_pkg::MAIN_OUTPUT,
                  hrdp_pkg::MAIN_FEATURE: begin
                     if (cur_emitted < CW'(hrdp_pkg::MaxFields)) begin
                        emit = 1'b1;
                        offset_in[kind] = cur_offset + product;
                        emitted_in[kind] = cur_emitted + CW'(1);
                     end
                     seen_in = 1'b0;
                     umin_in = 32'd0;
                     umax_in = 32'd0;
                  end
                  hrdp_pkg::MAIN_COLLECTION, hrdp_pkg::MAIN_END_COLLECTION: begin
                     seen_in = 1'b0;
                     umin_in = 32'd0;
                     umax_in = 32'd0;
                  end
                  default: ;
               endcase
            end
            hrdp_pkg::TYPE_GLOBAL: begin
               case (item.tag)
                  hrdp_pkg::GLB_PAGE: glb_in.page = item.value[15:0];
                  hrdp_pkg::GLB_LOG_MIN:
                     glb_in.log_min = hrdp_pkg::sign_by_size(item.value, item.code);
                  hrdp_pkg::GLB_LOG_MAX:
                     glb_in.log_max = hrdp_pkg::sign_by_size(item.value, item.code);
                  hrdp_pkg::GLB_PHY_MIN: glb_in.phy_min = item.value;
                  hrdp_pkg::GLB_PHY_MAX: glb_in.phy_max = item.value;
                  hrdp_pkg::GLB_EXPONENT: glb_in.exponent = item.value[3:0];
                  hrdp_pkg::GLB_UNIT: glb_in.unit = item.value;
                  hrdp_pkg::GLB_SIZE: glb_in.size = item.value;
                  hrdp_pkg::GLB_ID: glb_in.id = item.value[7:0];
                  hrdp_pkg::GLB_COUNT: glb_in.count = item.value;
                  hrdp_pkg::GLB_PUSH: begin
                     if (depth_cur < DW'(hrdp_pkg::PushStackDepth)) begin
                        push_we = 1'b1;
                        depth_in = depth_cur + DW'(1);
                     end
                  end
                  hrdp_pkg::GLB_POP: begin
                     if (depth_cur != '0) begin
                        pop_now = 1'b1;
                        depth_in = depth_cur - DW'(1);
                        glb_in = top_ff;
                     end
                  end
                  default: ;
               endcase
            end
            hrdp_pkg::TYPE_LOCAL: begin
               case (item.tag)
                  hrdp_pkg::LOC_USAGE: begin
                     if (!seen_cur) umin_in = usage_word;
                     umax_in = usage_word;
                     seen_in = 1'b1;
                  end
                  hrdp_pkg::LOC_USAGE_MIN: umin_in = usage_word;
                  hrdp_pkg::LOC_USAGE_MAX: umax_in = usage_word;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // Write the push stack; keep a registered copy of its top entry.
   always_ff @(posedge clock) begin
      if (take && push_we) begin
         stack_mem[push_idx] <= glb_cur;
         top_ff <= glb_cur;
      end else if (take && pop_now) begin
         top_ff <= stack_mem[below_idx];
      end
   end

   // Hold parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         glb_ff <= '0;
         depth_ff <= '0;
         seen_ff <= 1'b0;
         umin_ff <= 32'd0;
         umax_ff <= 32'd0;
         for (int k = 0; k < 3; k++) begin
            offset_ff[k] <= 32'd0;
            emitted_ff[k] <= '0;
         end
      end else if (take) begin
         glb_ff <= glb_in;
         depth_ff <= depth_in;
         seen_ff <= seen_in;
         umin_ff <= umin_in;
         umax_ff <= umax_in;
         for (int k = 0; k < 3; k++) begin
            offset_ff[k] <= offset_in[k];
            emitted_ff[k] <= emitted_in[k];
         end
      end
   end

   // Load the result register; drop it once transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= emit;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_report_kind <= kind;
         rsp_report_number <= glb_cur.id;
         rsp_main_flags <= item.value;
         rsp_first_usage <= umin_cur;
         rsp_final_usage <= umax_cur;
         rsp_logical_range <= {glb_cur.log_max, glb_cur.log_min};
         rsp_physical_range <= {glb_cur.phy_max, glb_cur.phy_min};
         rsp_unit_code <= glb_cur.unit;
         rsp_unit_power <= glb_cur.exponent;
         rsp_bits_per_element <= glb_cur.size;
         rsp_element_count <= glb_cur.count;
         rsp_field_bit_position <= cur_offset;
      end
   end

   assign rsp_valid = out_valid_ff;

   `HRDP_ASSERT_IMPL(a_stack_bound, clock, reset, 1'b1,
      depth_ff <= DW'(hrdp_pkg::PushStackDepth))
   `HRDP_ASSERT_IMPL(a_no_push_pop, clock, reset, 1'b1, !(push_we && pop_now))
   `HRDP_ASSERT_NEXT(a_emit_valid, clock, reset, take && emit, rsp_valid)
   `HRDP_ASSERT_IMPL(a_kind_range, clock, reset, rsp_valid,
      rsp_report_kind != 2'd3)
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the HID report descriptor parser: predicted field records checked in order.
`timescale 1ns / 1ps
module tb_top;
   localparam logic [1:0] TypeReserved = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       sod;
      logic       hold_off;   // pause here until all records have come
   } byte_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  number;
      logic [31:0] flags;
      logic [31:0] umin;
      logic [31:0] umax;
      logic [63:0] logical;
      logic [63:0] physical;
      logic [31:0] unit;
      logic [3:0]  power;
      logic [31:0] size;
      logic [31:0] count;
      logic [31:0] offset;
   } field_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_descriptor_byte = 8'd0;
   logic req_start_of_descriptor = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_report_kind;
   logic [7:0] rsp_report_number;
   logic [31:0] rsp_main_flags, rsp_first_usage, rsp_final_usage;
   logic [63:0] rsp_logical_range, rsp_physical_range;
   logic [31:0] rsp_unit_code;
   logic [3:0] rsp_unit_power;
   logic [31:0] rsp_bits_per_element, rsp_element_count, rsp_field_bit_position;

   hid_report_descriptor_parser_core dut (.*);

   always #5 clock = ~clock;

   // Parser model state
   hrdp_pkg::phase_type  m_phase;
   logic [8:0]           m_left;
   logic [7:0]           m_header;
   logic [31:0]          m_data;
   hrdp_pkg::global_type m_glb;
   hrdp_pkg::global_type m_stack [hrdp_pkg::PushStackDepth];
   int unsigned          m_depth;
   logic                 m_seen;
   logic [31:0]          m_umin, m_umax;
   logic [31:0]          m_offset [3];
   int unsigned          m_emitted [3];

   byte_item_type  pending_bytes [$];
   field_rec_type  expected_records [$];
   int unsigned error_count = 0;
   bit          stim_done = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("tb_top: mismatch %s got %h want %h", what, got, want);
      error_count++;
   endtask

   function automatic void parser_clear();
      m_phase = hrdp_pkg::PHASE_HEADER;
      m_left = 9'd0;
      m_header = 8'd0;
      m_data = 32'd0;
      m_glb = '0;
      m_depth = 0;
      m_seen = 1'b0;
      m_umin = 32'd0;
      m_umax = 32'd0;
      for (int k = 0; k < 3; k++) begin
         m_offset[k] = 32'd0;
         m_emitted[k] = 0;
      end
   endfunction

   function automatic logic [31:0] extend_by_code(logic [31:0] v, logic [1:0] code);
      case (code)
         2'd1: return {{24{v[7]}}, v[7:0]};
         2'd2: return {{16{v[15]}}, v[15:0]};
         2'd3: return v;
         default: return 32'd0;
      endcase
   endfunction

   function automatic void emit_record(logic [1:0] kind, logic [31:0] flags);
      field_rec_type r;
      if (m_emitted[kind] >= hrdp_pkg::MaxFields) return;
      r.kind = kind;
      r.number = m_glb.id;
      r.flags = flags;
      r.umin = m_umin;
      r.umax = m_umax;
      r.logical = {m_glb.log_max, m_glb.log_min};
      r.physical = {m_glb.phy_max, m_glb.phy_min};
      r.unit = m_glb.unit;
      r.power = m_glb.exponent;
      r.size = m_glb.size;
      r.count = m_glb.count;
      r.offset = m_offset[kind];
      m_offset[kind] += m_glb.size * m_glb.count;
      m_emitted[kind]++;
      expected_records.push_back(r);
   endfunction

   function automatic void finish_item();
      logic [1:0] code, ty;
      logic [3:0] tag;
      logic [31:0] v, u;
      code = m_header[1:0];
      ty = m_header[3:2];
      tag = m_header[7:4];
      v = m_data;
      if (code == 2'd1) v = v >> 24;
      else if (code == 2'd2) v = v >> 16;
      else if (code == 2'd0) v = 32'd0;
      m_phase = hrdp_pkg::PHASE_HEADER;
      m_data = 32'd0;
      u = {m_glb.page, v[15:0]};
      if (ty == hrdp_pkg::TYPE_MAIN) begin
         case (tag)
            hrdp_pkg::MAIN_INPUT:   emit_record(hrdp_pkg::KIND_INPUT, v);
            hrdp_pkg::MAIN_OUTPUT:  emit_record(hrdp_pkg::KIND_OUTPUT, v);
            hrdp_pkg::MAIN_FEATURE: emit_record(hrdp_pkg::KIND_FEATURE, v);
            default: ;
         endcase
         if (tag inside {hrdp_pkg::MAIN_INPUT, hrdp_pkg::MAIN_OUTPUT,
                         hrdp_pkg::MAIN_FEATURE, hrdp_pkg::MAIN_COLLECTION,
                         hrdp_pkg::MAIN_END_COLLECTION}) begin
            m_seen = 1'b0;
            m_umin = 32'd0;
            m_umax = 32'd0;
         end
      end else if (ty == hrdp_pkg::TYPE_GLOBAL) begin
         case (tag)
            hrdp_pkg::GLB_PAGE:     m_glb.page = v[15:0];
            hrdp_pkg::GLB_LOG_MIN:  m_glb.log_min = extend_by_code(v, code);
            hrdp_pkg::GLB_LOG_MAX:  m_glb.log_max = extend_by_code(v, code);
            hrdp_pkg::GLB_PHY_MIN:  m_glb.phy_min = v;
            hrdp_pkg::GLB_PHY_MAX:  m_glb.phy_max = v;
            hrdp_pkg::GLB_EXPONENT: m_glb.exponent = v[3:0];
            hrdp_pkg::GLB_UNIT:     m_glb.unit = v;
            hrdp_pkg::GLB_SIZE:     m_glb.size = v;
            hrdp_pkg::GLB_ID:       m_glb.id = v[7:0];
            hrdp_pkg::GLB_COUNT:    m_glb.count = v;
            hrdp_pkg::GLB_PUSH: if (m_depth < hrdp_pkg::PushStackDepth) begin
               m_stack[m_depth] = m_glb;
               m_depth++;
            end
            hrdp_pkg::GLB_POP: if (m_depth > 0) begin
               m_depth--;
               m_glb = m_stack[m_depth];
            end
            default: ;
         endcase
      end else if (ty == hrdp_pkg::TYPE_LOCAL) begin
         case (tag)
            hrdp_pkg::LOC_USAGE: begin
               if (!m_seen) m_umin = u;
               m_umax = u;
               m_seen = 1'b1;
            end
            hrdp_pkg::LOC_USAGE_MIN: m_umin = u;
            hrdp_pkg::LOC_USAGE_MAX: m_umax = u;
            default: ;
         endcase
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic sod);
      if (sod) parser_clear();
      case (m_phase)
         hrdp_pkg::PHASE_SHORT_DATA: begin
            m_data = {b, m_data[31:8]};
            if (m_left > 0) m_left--;
            if (m_left == 0) finish_item();
         end
         hrdp_pkg::PHASE_LONG_LEN: begin
            m_left = {1'b0, b} + 9'd1;
            m_phase = hrdp_pkg::PHASE_LONG_SKIP;
         end
         hrdp_pkg::PHASE_LONG_SKIP: begin
            if (m_left > 0) m_left--;
            if (m_left == 0) m_phase = hrdp_pkg::PHASE_HEADER;
         end
         default: begin
            m_header = b;
            m_data = 32'd0;
            if (b == hrdp_pkg::LongItemHeader) m_phase = hrdp_pkg::PHASE_LONG_LEN;
            else begin
               case (b[1:0])
                  2'd1: m_left = 9'd1;
                  2'd2: m_left = 9'd2;
                  2'd3: m_left = 9'd4;
                  default: m_left = 9'd0;
               endcase
               if (m_left == 0) finish_item();
               else m_phase = hrdp_pkg::PHASE_SHORT_DATA;
            end
         end
      endcase
   endfunction

   // Stimulus building; the generator tracks push depth of each descriptor
   int unsigned gen_depth = 0;
   int unsigned gen_count = 0;

   task automatic add_byte(input logic [7:0] b, input logic sod = 0,
                           input logic hold = 0);
      pending_bytes.push_back({b, sod, hold});
      gen_count++;
   endtask

   task automatic add_item(input logic [1:0] ty, input logic [3:0] tag,
                           input logic [1:0] code, input logic [31:0] v,
                           input logic sod = 0);
      int n;
      if (ty == hrdp_pkg::TYPE_GLOBAL && tag == hrdp_pkg::GLB_POP && gen_depth > 0)
         gen_depth--;
      if (ty == hrdp_pkg::TYPE_GLOBAL && tag == hrdp_pkg::GLB_PUSH &&
          gen_depth < hrdp_pkg::PushStackDepth) gen_depth++;
      add_byte({tag, ty, code}, sod);
      n = (code == 3) ? 4 : int'(code);
      for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
   endtask

   task automatic add_random_item();
      int sel;
      logic [1:0] code;
      logic [31:0] v;
      code = 2'($urandom_range(0, 3));
      v = $urandom;
      if ($urandom_range(0, 3) == 0) v = ($urandom_range(0, 1)) ? 32'hFFFFFFFF : 32'h0;
      sel = $urandom_range(0, 99);
      if (sel < 12) add_item(hrdp_pkg::TYPE_MAIN, $urandom_range(0, 1) ? hrdp_pkg::MAIN_INPUT :
                             ($urandom_range(0, 1) ? hrdp_pkg::MAIN_OUTPUT :
                              hrdp_pkg::MAIN_FEATURE), code, v);
      else if (sel < 15) add_item(hrdp_pkg::TYPE_MAIN, 4'($urandom_range(0, 15)), code, v);
      else if (sel < 60) add_item(hrdp_pkg::TYPE_GLOBAL, 4'($urandom_range(0, 11)), code, v);
      else if (sel < 63) add_item(hrdp_pkg::TYPE_GLOBAL, 4'($urandom_range(12, 15)), code, v);
      else if (sel < 85) add_item(hrdp_pkg::TYPE_LOCAL, 4'($urandom_range(0, 2)), code, v);
      else if (sel < 90) add_item(hrdp_pkg::TYPE_LOCAL, 4'($urandom_range(3, 15)), code, v);
      else if (sel < 94) add_item(TypeReserved, 4'($urandom_range(0, 15)), code, v);
      else begin
         int len;
         len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 4);
         add_byte(hrdp_pkg::LongItemHeader);
         add_byte(8'(len));
         add_byte(8'($urandom));
         for (int i = 0; i < len; i++) add_byte(8'($urandom));
      end
   endtask

   initial begin
      // Directed: extremes, every item class, sign extension, push/pop edges
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_LOG_MIN, 2'd1, 32'h80, 1);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_LOG_MAX, 2'd2, 32'h7FFF);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_PHY_MIN, 2'd3, 32'hFFFFFFFF);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_SIZE, 2'd1, 32'h08);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_COUNT, 2'd1, 32'h03);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_POP, 2'd0, 0);
      add_item(hrdp_pkg::TYPE_LOCAL, hrdp_pkg::LOC_USAGE, 2'd1, 32'h05);
      add_item(hrdp_pkg::TYPE_LOCAL, hrdp_pkg::LOC_USAGE, 2'd2, 32'hFFFF);
      add_item(hrdp_pkg::TYPE_MAIN, hrdp_pkg::MAIN_INPUT, 2'd1, 32'h02);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_PUSH, 2'd0, 0);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_LOG_MIN, 2'd2, 32'h8000);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_LOG_MAX, 2'd0, 0);
      add_item(hrdp_pkg::TYPE_MAIN, hrdp_pkg::MAIN_OUTPUT, 2'd0, 0);
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_POP, 2'd0, 0);
      add_byte(hrdp_pkg::LongItemHeader);
      add_byte(8'd2);
      add_byte(8'h11);
      add_byte(8'hAA);
      add_byte(8'h55);
      add_item(hrdp_pkg::TYPE_MAIN, hrdp_pkg::MAIN_FEATURE, 2'd3, 32'hFFFFFFFF);
      add_item(TypeReserved, 4'h8, 2'd0, 0);
      add_byte(8'h27);      // unfinished item cut by a new descriptor
      add_item(hrdp_pkg::TYPE_MAIN, hrdp_pkg::MAIN_INPUT, 2'd0, 0, 1);
      // Fill the push stack past full, then drain it past empty
      for (int i = 0; i < hrdp_pkg::PushStackDepth + 1; i++)
         add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_PUSH, 2'd0, 0);
      for (int i = 0; i < hrdp_pkg::PushStackDepth + 2; i++)
         add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_POP, 2'd0, 0);
      pending_bytes[pending_bytes.size() - 1].hold_off = 1;
      // Random descriptors
      while (gen_count < 300) begin
         int items;
         items = $urandom_range(5, 60);
         add_byte(8'h00, 1);      // empty main item, starts a new descriptor
         gen_depth = 0;
         for (int i = 0; i < items; i++) add_random_item();
      end
      // One long descriptor that hits the per-kind field limit
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_SIZE, 2'd1, 32'h01, 1);
      gen_depth = 0;
      add_item(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::GLB_COUNT, 2'd1, 32'h02);
      for (int i = 0; i < hrdp_pkg::MaxFields + 4; i++)
         add_item(hrdp_pkg::TYPE_MAIN, hrdp_pkg::MAIN_FEATURE, 2'd0, 0);
      add_item(hrdp_pkg::TYPE_MAIN, hrdp_pkg::MAIN_INPUT, 2'd0, 0);
      stim_done = 1;
   end

   // Sample input transfers at the rising edge
   bit req_taken = 0;
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
   end

   // Driver: bursts and gaps, change at the falling edge
   int unsigned burst_left = 0, gap_left = 0;
   bit waiting_drain = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            predict_byte(req_descriptor_byte, req_start_of_descriptor);
            void'(pending_bytes.pop_front());
         end
         if (req_valid && !req_taken) begin
            // hold the stalled transfer
         end else if (waiting_drain) begin
            req_valid <= 1'b0;
            if (expected_records.size() == 0) waiting_drain = 0;
         end else if (pending_bytes.size() != 0 && pending_bytes[0].hold_off &&
                      expected_records.size() != 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
            burst_left--;
            req_valid <= 1'b1;
            req_descriptor_byte <= pending_bytes[0].data;
            req_start_of_descriptor <= pending_bytes[0].sod;
            if (pending_bytes[0].hold_off) waiting_drain = 1;
         end
      end
   end

   // Receiver stall pattern with one long hold-off
   int unsigned rx_cycle = 0;
   always @(negedge clock) begin
      if (!reset) begin
         rx_cycle++;
         if (rx_cycle >= 200 && rx_cycle < 500) begin
            rsp_stall <= 1'b1;
         end else begin
            case ((rx_cycle / 100) % 3)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   // Monitor: compare each record against the oldest expectation
   always @(posedge clock) begin
      field_rec_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            report_mismatch("unexpected record", 64'd0, 64'd0);
         end else begin
            w = expected_records.pop_front();
            if (rsp_report_kind !== w.kind)
               report_mismatch("kind", 64'(rsp_report_kind), 64'(w.kind));
            if (rsp_report_number !== w.number)
               report_mismatch("number", 64'(rsp_report_number), 64'(w.number));
            if (rsp_main_flags !== w.flags)
               report_mismatch("flags", 64'(rsp_main_flags), 64'(w.flags));
            if (rsp_first_usage !== w.umin)
               report_mismatch("umin", 64'(rsp_first_usage), 64'(w.umin));
            if (rsp_final_usage !== w.umax)
               report_mismatch("umax", 64'(rsp_final_usage), 64'(w.umax));
            if (rsp_logical_range !== w.logical)
               report_mismatch("logical", rsp_logical_range, w.logical);
            if (rsp_physical_range !== w.physical)
               report_mismatch("physical", rsp_physical_range, w.physical);
            if (rsp_unit_code !== w.unit)
               report_mismatch("unit", 64'(rsp_unit_code), 64'(w.unit));
            if (rsp_unit_power !== w.power)
               report_mismatch("power", 64'(rsp_unit_power), 64'(w.power));
            if (rsp_bits_per_element !== w.size)
               report_mismatch("size", 64'(rsp_bits_per_element), 64'(w.size));
            if (rsp_element_count !== w.count)
               report_mismatch("count", 64'(rsp_element_count), 64'(w.count));
            if (rsp_field_bit_position !== w.offset)
               report_mismatch("offset", 64'(rsp_field_bit_position), 64'(w.offset));
         end
      end
   end

   // Watchdog: idle cycles without any transfer
   int unsigned idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      parser_clear();
      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (stim_done && pending_bytes.size() == 0 && !req_valid);
      wait (expected_records.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_records.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule

[hid_report_descriptor_parser_core.f]
+incdir+hw/rtl
hw/rtl/hrdp_pkg.sv
hw/rtl/hrdp_item_asm.sv
hw/rtl/hid_report_descriptor_parser_core.sv
dv/tb_top.sv
